// ===== rtl/rhe_pkg.sv =====
// Package: shared types, constants and codes for the range histogram engine.
`default_nettype none
package rhe_pkg;

    localparam int MAX_BINS = 256;
    localparam int IDX_W    = $clog2(MAX_BINS);
    localparam int NB_W     = IDX_W + 1;

    // Operation codes.
    localparam logic [1:0] OP_HIT  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_NORM = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOW  = 2'd0;
    localparam logic [1:0] CFG_HIGH = 2'd1;
    localparam logic [1:0] CFG_BINS = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] sample;
        logic [15:0]        norm_target;
    } in_beat_t;

    typedef struct packed {
        logic [31:0]        bin_value;
        logic               in_range;
        logic [7:0]         peak_index;
        logic [31:0]        hit_total;
        logic signed [63:0] value_sum;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_LOOKUP,
        ST_APPLY,
        ST_PEAK,
        ST_SCALE_RD,
        ST_SCALE_DIV,
        ST_SCALE_WR,
        ST_OUT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic load;
        logic div_step;
        logic apply;
        logic peak_start;
        logic peak_step;
        logic peak_done;
        logic scale_start;
        logic scale_rd;
        logic sdiv_start;
        logic scale_wr;
        logic result;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic peak_last;
        logic peak_zero;
        logic scale_last;
        logic [1:0] op;
    } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rhe_ctrl.sv =====
// Controller state machine for the range histogram engine.
`default_nettype none
module rhe_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output rhe_pkg::dp_cmd_t     cmd,
    input  wire rhe_pkg::dp_sts_t sts
);
    import rhe_pkg::*;

    state_t state_reg, state_next;
    logic   started_reg, started_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (!started_reg)
                begin
                    cmd.clr_start = 1'b1;
                    started_next  = 1'b1;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                    if (sts.clr_last)
                    begin
                        started_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.op == OP_NORM)
                begin
                    cmd.peak_start = 1'b1;
                    state_next = ST_PEAK;
                end
                else if (sts.op != OP_HIT && sts.op != OP_READ)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_done)
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                cmd.result = 1'b1;
                state_next = ST_OUT;
            end
            ST_PEAK:
            begin
                cmd.peak_step = 1'b1;
                if (sts.peak_last)
                begin
                    state_next = ST_SCALE_RD;
                end
            end
            ST_SCALE_RD:
            begin
                // Peak registered here; start scaling unless it is zero.
                cmd.peak_done = 1'b1;
                if (sts.peak_zero)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.scale_start = 1'b1;
                    cmd.scale_rd    = 1'b1;
                    state_next = ST_SCALE_DIV;
                end
            end
            ST_SCALE_DIV:
            begin
                if (!started_reg)
                begin
                    cmd.sdiv_start = 1'b1;
                    started_next   = 1'b1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_done)
                    begin
                        started_next = 1'b0;
                        state_next   = ST_SCALE_WR;
                    end
                end
            end
            ST_SCALE_WR:
            begin
                cmd.scale_wr = 1'b1;
                if (sts.scale_last)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.scale_rd = 1'b1;
                    state_next   = ST_SCALE_DIV;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/rhe_datapath.sv =====
// Datapath: bin store, shared restoring divider, peak search and counters.
`default_nettype none
module rhe_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire rhe_pkg::in_beat_t in_beat,
    input  wire rhe_pkg::dp_cmd_t  cmd,
    output rhe_pkg::dp_sts_t       sts,
    output rhe_pkg::out_beat_t     out_beat
);
    import rhe_pkg::*;

    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    // Configuration registers.
    logic signed [31:0] low_reg, high_reg;
    logic [8:0]         bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= 32'sd0;
            high_reg <= 32'sd65536;
            bins_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOW:  low_reg  <= cfg_data;
                CFG_HIGH: high_reg <= cfg_data;
                CFG_BINS: bins_reg <= cfg_data[8:0];
                default:  ;
            endcase
        end
    end

    // Effective bin count.
    logic [NB_W-1:0] nbins;
    always_comb
    begin
        if (bins_reg == 9'd0)
            nbins = NB_W'(1);
        else if ({23'd0, bins_reg} > 32'(MAX_BINS))
            nbins = NB_W'(MAX_BINS);
        else
            nbins = NB_W'(bins_reg);
    end

    // Item registers.
    logic [1:0]         op_reg;
    logic signed [31:0] sample_reg;
    logic [15:0]        target_reg;
    logic               valid_rng_reg;

    // Shared restoring divider: 64-bit dividend, 33-bit divisor.
    logic [63:0] dq_reg;
    logic [33:0] rem_reg;
    logic [32:0] dvs_reg;
    logic [6:0]  dcnt_reg;
    logic [33:0] rem_shift, rem_sub;

    assign rem_shift = {rem_reg[32:0], dq_reg[63]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    // Hit/read operands.
    logic signed [32:0] diff, span;
    assign diff = 33'(sample_reg) - 33'(low_reg);
    assign span = 33'(high_reg) - 33'(low_reg);

    // Bin store and its read data.
    logic [31:0] mem [MAX_BINS];
    logic [31:0] rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0] wr_data;
    logic [IDX_W-1:0] wr_addr;
    logic wr_en;

    // Counters and normalization state.
    logic [NB_W-1:0]  ptr_reg;
    logic [NB_W-1:0]  pscan_reg;
    logic [31:0]      max_reg;
    logic [IDX_W-1:0] pidx_reg;
    logic [7:0]       peak_reg;
    logic [31:0]      count_reg;
    logic signed [63:0] sum_reg;
    logic [31:0]      value_reg;
    logic             inr_reg;
    logic             pscan_vld_reg;
    logic [IDX_W-1:0] pscan_idx_reg;

    // Bin index and range check after division.
    logic in_rng;
    assign in_rng = valid_rng_reg && (dq_reg[63:NB_W] == '0) && (dq_reg[NB_W-1:0] < nbins);

    always_comb
    begin
        rd_addr = dq_reg[IDX_W-1:0];
        if (cmd.peak_step)
            rd_addr = pscan_reg[IDX_W-1:0] - IDX_W'(1);
        else if (cmd.scale_rd)
            rd_addr = cmd.scale_start ? '0 : ptr_reg[IDX_W-1:0] + IDX_W'(1);
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = dq_reg[IDX_W-1:0];
        wr_data = rd_reg + 32'd1;
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = ptr_reg[IDX_W-1:0];
            wr_data = '0;
        end
        else if (cmd.apply && op_reg == OP_HIT && in_rng)
        begin
            wr_en = (rd_reg != 32'hFFFF_FFFF);
        end
        else if (cmd.scale_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = ptr_reg[IDX_W-1:0];
            wr_data = dq_reg[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    // Main datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            pscan_reg <= '0;
            pscan_vld_reg <= 1'b0;
            pscan_idx_reg <= '0;
            max_reg   <= '0;
            pidx_reg  <= '0;
            peak_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            value_reg <= '0;
            inr_reg   <= 1'b0;
            dcnt_reg  <= '0;
            op_reg    <= '0;
            sample_reg <= '0;
            target_reg <= '0;
            dq_reg    <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            valid_rng_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_start)
                ptr_reg <= '0;
            if (cmd.clr_step)
                ptr_reg <= ptr_reg + NB_W'(1);

            // Take in the item and set up the bin-index division.
            if (cmd.load)
            begin
                op_reg     <= in_beat.operation;
                sample_reg <= in_beat.sample;
                target_reg <= in_beat.norm_target;
                dcnt_reg   <= 7'd64;
            end

            if (cmd.div_step)
            begin
                if (dcnt_reg == 7'd64 && !cmd.sdiv_start && op_reg != OP_NORM)
                begin
                    // First step of a locate: form diff * n and the span.
                    // The product stays below 2^41, so it sits one place up
                    // and the 63 steps that follow take in all of its bits.
                    valid_rng_reg <= (span > 0) && (diff >= 0);
                    dq_reg  <= (64'(diff[31:0] & {32{~diff[32]}}) * 64'(nbins)) << 1;
                    dvs_reg <= span[32:0];
                    rem_reg <= '0;
                    dcnt_reg <= 7'd63;
                end
                else
                begin
                    if (!rem_sub[33])
                    begin
                        rem_reg <= rem_sub;
                        dq_reg  <= {dq_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        dq_reg  <= {dq_reg[62:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 7'd1;
                end
            end

            // Apply a hit or capture a read.
            if (cmd.apply)
            begin
                inr_reg   <= in_rng;
                value_reg <= (op_reg == OP_READ && in_rng) ? rd_reg : 32'd0;
                if (op_reg == OP_HIT && in_rng)
                begin
                    if (count_reg != 32'hFFFF_FFFF)
                        count_reg <= count_reg + 32'd1;
                    if (sample_reg > 0 && sum_reg > SUM_MAX - 64'(sample_reg))
                        sum_reg <= SUM_MAX;
                    else if (sample_reg < 0 && sum_reg < SUM_MIN - 64'(sample_reg))
                        sum_reg <= SUM_MIN;
                    else
                        sum_reg <= sum_reg + 64'(sample_reg);
                end
            end
            if (cmd.result && !cmd.apply)
            begin
                inr_reg   <= 1'b0;
                value_reg <= '0;
            end

            // Peak search, highest index first; bin 0 wins ties.
            if (cmd.peak_start)
            begin
                pscan_reg     <= nbins;
                pscan_vld_reg <= 1'b0;
                max_reg       <= '0;
                pidx_reg      <= '0;
            end
            if (cmd.peak_step)
            begin
                pscan_reg     <= pscan_reg - NB_W'(1);
                pscan_vld_reg <= 1'b1;
                pscan_idx_reg <= pscan_reg[IDX_W-1:0] - IDX_W'(1);
            end
            if ((cmd.peak_step || cmd.peak_done) && pscan_vld_reg)
            begin
                if (rd_reg > max_reg || (pscan_idx_reg == '0 && rd_reg == max_reg))
                begin
                    max_reg  <= rd_reg;
                    pidx_reg <= pscan_idx_reg;
                end
            end
            if (cmd.peak_done)
                pscan_vld_reg <= 1'b0;

            // Scaling pass: count * target / peak. The 48-bit product sits in
            // the top of the dividend so 48 steps leave the quotient low.
            if (cmd.scale_start)
                ptr_reg <= '0;
            if (cmd.sdiv_start)
            begin
                dq_reg   <= {48'(64'(rd_reg) * 64'(target_reg)), 16'd0};
                dvs_reg  <= {1'b0, max_reg};
                rem_reg  <= '0;
                dcnt_reg <= 7'd48;
            end
            if (cmd.scale_wr)
                ptr_reg <= ptr_reg + NB_W'(1);
            if (cmd.result && op_reg == OP_NORM)
                peak_reg <= 8'(pidx_reg);
        end
    end

    // Peak result as seen in the decision cycle (includes the last compare).
    logic [31:0] peak_final;
    always_comb
    begin
        peak_final = max_reg;
        if (pscan_vld_reg && rd_reg > max_reg)
            peak_final = rd_reg;
    end

    assign sts.clr_last   = (ptr_reg == NB_W'(MAX_BINS - 1));
    assign sts.div_done   = (dcnt_reg == 7'd1);
    assign sts.peak_last  = (pscan_reg == NB_W'(1));
    assign sts.peak_zero  = (peak_final == 32'd0);
    assign sts.scale_last = (ptr_reg == nbins - NB_W'(1));
    assign sts.op         = op_reg;

    assign out_beat.bin_value  = value_reg;
    assign out_beat.in_range   = inr_reg;
    assign out_beat.peak_index = peak_reg;
    assign out_beat.hit_total  = count_reg;
    assign out_beat.value_sum  = sum_reg;
endmodule
`default_nettype wire

// ===== rtl/range_histogram_engine_top.sv =====
// Top level of the range histogram engine.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall | rhe_pkg::in_beat_t
//  out     | output    | out_valid/out_stall | rhe_pkg::out_beat_t
//  cfg     | input     | cfg_we           | cfg_index, cfg_data
//
// A hit or read runs a setup step, 63 restoring divider steps, a lookup and
// an apply, then offers its result.
// A normalize scans the n bins for the peak, then runs a 48-step divide and
// a write per bin, or skips the scaling when the peak is zero.
// After reset a clearing pass over all bins runs before the first beat is accepted.
// A result stays in its output register until taken; stalls only lengthen the item.
`default_nettype none
module range_histogram_engine_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire rhe_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output rhe_pkg::out_beat_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import rhe_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rhe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rhe_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_beat  (out_data)
    );
endmodule
`default_nettype wire

// ===== rtl/rhe_checker.sv =====
// Port-level checker for the range histogram engine, bound to the top level.
`default_nettype none
module rhe_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire rhe_pkg::out_beat_t out_data
);
    import rhe_pkg::*;

    // One item at a time: no input beat while a result is shown.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while result pending");

    // An accepted input is followed by input stall next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

    // A zero bin value is reported when out of range.
    a_range_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.in_range) |-> (out_data.bin_value == 32'd0))
        else $error("bin value without in-range");
endmodule

bind range_histogram_engine_top rhe_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
